// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the beacon detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion violated");
// Check that a condition is never seen outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

// ===== design/rbd_pkg.sv =====
// Package of constants, types and functions for the range/bearing beacon detector.
`default_nettype none

package rbd_pkg;

   // Number of CORDIC micro-rotations (8 to 32).
   localparam int CORDIC_STAGES = 16;
   // Fractional guard bits added to the offset before rotation.
   localparam int GUARD_BITS = 8;
   // Width of the rotating x/y datapath; covers gain growth of a 33-bit offset.
   localparam int XW = 44;
   // Width of the angle accumulator (2^32 is a full turn).
   localparam int ZW = 32;
   // Width of the stage index.
   localparam int IDXW = 5;

   // Inverse CORDIC gain, Q0.32.
   localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
   // Half an angle LSB of the 16-bit bearing, for rounding.
   localparam logic [ZW-1:0] ANGLE_ROUND = 32'h0000_8000;
   // Half angle turn.
   localparam logic [ZW-1:0] ANGLE_PI = 32'h8000_0000;

   // Reset values of the control registers.
   localparam logic [31:0] MAX_RANGE_RST = 32'd5898240;
   localparam logic        REPORT_ID_RST = 1'b1;

   // Register indexes of the control port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_ID = 2'd1;

   // Identifier reported when identity reporting is off.
   localparam logic signed [16:0] IDENT_NONE = -17'sd1;

   // One item in flight through the rotation pipeline.
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic [ZW-1:0]        z;
      logic [15:0]          heading;
      logic [15:0]          ident;
   } cordic_item_type;

   // atan(2^-i) in 32-bit binary-angle units, truncated.
   function automatic logic [ZW-1:0] atan_angle(input logic [IDXW-1:0] idx);
      logic [ZW-1:0] a;
      begin
         case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933405;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10680862;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335086;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41721;
            5'd15: a = 32'd20860;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2607;
            5'd19: a = 32'd1303;
            5'd20: a = 32'd651;
            5'd21: a = 32'd325;
            5'd22: a = 32'd162;
            5'd23: a = 32'd81;
            5'd24: a = 32'd40;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd2;
            5'd29: a = 32'd1;
            default: a = 32'd0;
         endcase
         return a;
      end
   endfunction

   // One vectoring micro-rotation: drive y toward zero.
   function automatic cordic_item_type cordic_step(input cordic_item_type it,
                                                    input logic [IDXW-1:0] idx);
      cordic_item_type      o;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      begin
         o  = it;
         xs = it.x >>> idx;
         ys = it.y >>> idx;
         if (!it.y[XW-1]) begin
            o.x = it.x + ys;
            o.y = it.y - xs;
            o.z = it.z + atan_angle(idx);
         end else begin
            o.x = it.x - ys;
            o.y = it.y + xs;
            o.z = it.z - atan_angle(idx);
         end
         return o;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/rbd_cordic_pipe.sv =====
// Pipelined CORDIC vectoring core: one register stage per micro-rotation.
`default_nettype none

module rbd_cordic_pipe (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_stall,
   input  wire rbd_pkg::cordic_item_type in_item,
   output logic                          out_valid,
   input  wire logic                     out_stall,
   output rbd_pkg::cordic_item_type      out_item
);

   localparam int N = rbd_pkg::CORDIC_STAGES;

   logic [N-1:0]             valid_ff;
   rbd_pkg::cordic_item_type item_ff [N];
   logic [N-1:0]             adv;

   function automatic logic [rbd_pkg::IDXW-1:0] IDXW_CAST(input int v);
      return v[rbd_pkg::IDXW-1:0];
   endfunction

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                     src_valid;
      rbd_pkg::cordic_item_type src_item;

      // Pick the upstream beat for this stage.
      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_item  = in_item;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_item  = item_ff[k-1];
      end

      // Advance when empty or when the stage below takes the beat.
      if (k == N - 1) begin : g_last_adv
         assign adv[k] = !valid_ff[k] || !out_stall;
      end else begin : g_mid_adv
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k] && src_valid) begin
            item_ff[k] <= rbd_pkg::cordic_step(src_item, IDXW_CAST(k));
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[N-1];
   assign out_item  = item_ff[N-1];

endmodule

`default_nettype wire

// ===== design/range_bearing_beacon_detector.sv =====
// Top level of the range/bearing beacon detector.
//
// Usage: each req_ beat carries a sensor pose (x, y, heading) and one beacon
// (x, y, identifier). Each beat yields exactly one rsp_ beat, in order, with the
// range to the beacon (unsigned Q16.16, saturated), the bearing relative to the
// heading (binary angle, wrapped), a detected flag (range below max_range) and
// the identifier, or -1 when identity reporting is off.
// Control: csr_write with csr_index 0 sets max_range, index 1 sets
// report_identity; write only while no beat is in flight.
// Stages: one offset stage, one register per micro-rotation, a gain-multiply
// stage, an add stage and the output register. Throughput: one beat per cycle
// while rsp_stall is low, set by the fully pipelined rotation chain.
// Reset: synchronous; empties the pipeline and loads max_range = 90.0 and
// report_identity = 1.
// Stall: a stalled result holds in the output register; earlier stages keep
// accepting until every stage is full, then req_stall rises. Nothing is lost.
`default_nettype none
`include "assert_macros.svh"

module range_bearing_beacon_detector (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [31:0]   req_sensor_x,
   input  wire logic signed [31:0]   req_sensor_y,
   input  wire logic signed [15:0]   req_sensor_heading,
   input  wire logic signed [31:0]   req_beacon_x,
   input  wire logic signed [31:0]   req_beacon_y,
   input  wire logic [15:0]          req_beacon_ident,
   // Response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_detected,
   output logic [31:0]               rsp_distance,
   output logic signed [15:0]        rsp_bearing,
   output logic signed [16:0]        rsp_reported_ident,
   // Control registers
   input  wire logic                 csr_write,
   input  wire logic [rbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam int XW = rbd_pkg::XW;
   localparam int UXW = XW - 1;
   localparam int HIW = UXW - 16;
   localparam int AW = HIW + 32;
   localparam int BW = 49;
   localparam int SW = AW + 1;
   localparam int DW = SW - 24;
   localparam logic [BW-1:0] ROUND_BIAS = BW'(1) << (31 + rbd_pkg::GUARD_BITS);

   // Control registers
   logic [31:0] max_range_ff;
   logic        report_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= rbd_pkg::MAX_RANGE_RST;
         report_id_ff <= rbd_pkg::REPORT_ID_RST;
      end else if (csr_write) begin
         case (csr_index)
            rbd_pkg::CSR_MAX_RANGE: max_range_ff <= csr_wdata;
            rbd_pkg::CSR_REPORT_ID: report_id_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake advance terms, output side first
   logic adv_o, adv_a, adv_m, adv_p;
   logic pipe_in_stall, pipe_out_valid, pipe_out_stall;
   rbd_pkg::cordic_item_type pipe_out_item;

   logic p_valid_ff, m_valid_ff, a_valid_ff, rsp_valid_ff;

   assign adv_o          = !rsp_valid_ff || !rsp_stall;
   assign adv_a          = !a_valid_ff || adv_o;
   assign adv_m          = !m_valid_ff || adv_a;
   assign pipe_out_stall = !adv_m;
   assign adv_p          = !p_valid_ff || !pipe_in_stall;
   assign req_stall      = !adv_p;

   // Offset stage: form beacon minus sensor, fold into the right half-plane
   rbd_pkg::cordic_item_type p_item_ff, p_item_in;
   logic signed [32:0] dx_pos, dx_neg, dy_pos, dy_neg;

   always_comb begin
      dx_pos = 33'(req_beacon_x) - 33'(req_sensor_x);
      dx_neg = 33'(req_sensor_x) - 33'(req_beacon_x);
      dy_pos = 33'(req_beacon_y) - 33'(req_sensor_y);
      dy_neg = 33'(req_sensor_y) - 33'(req_beacon_y);
      p_item_in.heading = req_sensor_heading;
      p_item_in.ident   = req_beacon_ident;
      if (dx_pos[32]) begin
         p_item_in.x = XW'(dx_neg) <<< rbd_pkg::GUARD_BITS;
         p_item_in.y = XW'(dy_neg) <<< rbd_pkg::GUARD_BITS;
         p_item_in.z = rbd_pkg::ANGLE_PI;
      end else begin
         p_item_in.x = XW'(dx_pos) <<< rbd_pkg::GUARD_BITS;
         p_item_in.y = XW'(dy_pos) <<< rbd_pkg::GUARD_BITS;
         p_item_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv_p) begin
         p_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_p && req_valid) begin
         p_item_ff <= p_item_in;
      end
   end

   // Rotation chain
   rbd_cordic_pipe u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid_ff),
      .in_stall  (pipe_in_stall),
      .in_item   (p_item_ff),
      .out_valid (pipe_out_valid),
      .out_stall (pipe_out_stall),
      .out_item  (pipe_out_item)
   );

   // Gain stage: clamp x, split and multiply by 1/K; round the angle
   logic [UXW-1:0] ux;
   logic [HIW-1:0] x_hi;
   logic [15:0]    x_lo;
   logic [AW-1:0]  m_prod_hi_ff, m_prod_hi_in;
   logic [BW-1:0]  m_prod_lo_ff, m_prod_lo_in;
   logic [15:0]    m_bearing_ff, m_bearing_in;
   logic [15:0]    m_ident_ff;
   logic [31:0]    z_round;

   always_comb begin
      ux           = pipe_out_item.x[XW-1] ? '0 : pipe_out_item.x[UXW-1:0];
      x_hi         = ux[UXW-1:16];
      x_lo         = ux[15:0];
      m_prod_hi_in = AW'(x_hi) * AW'(rbd_pkg::INV_GAIN);
      m_prod_lo_in = BW'(x_lo) * BW'(rbd_pkg::INV_GAIN) + ROUND_BIAS;
      z_round      = pipe_out_item.z + rbd_pkg::ANGLE_ROUND;
      m_bearing_in = z_round[31:16] - pipe_out_item.heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv_m) begin
         m_valid_ff <= pipe_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_m && pipe_out_valid) begin
         m_prod_hi_ff <= m_prod_hi_in;
         m_prod_lo_ff <= m_prod_lo_in;
         m_bearing_ff <= m_bearing_in;
         m_ident_ff   <= pipe_out_item.ident;
      end
   end

   // Add stage: merge partial products and drop the fraction
   logic [SW-1:0] a_sum;
   logic [DW-1:0] a_dist_ff, a_dist_in;
   logic [15:0]   a_bearing_ff;
   logic [15:0]   a_ident_ff;

   always_comb begin
      a_sum     = SW'(m_prod_hi_ff) + SW'(m_prod_lo_ff[BW-1:16]);
      a_dist_in = a_sum[SW-1:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv_a) begin
         a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && m_valid_ff) begin
         a_dist_ff    <= a_dist_in;
         a_bearing_ff <= m_bearing_ff;
         a_ident_ff   <= m_ident_ff;
      end
   end

   // Output stage: saturate, compare against the limit, pick the identifier
   logic [31:0]        rsp_distance_ff, rsp_distance_in;
   logic               rsp_detected_ff;
   logic [15:0]        rsp_bearing_ff;
   logic signed [16:0] rsp_ident_ff, rsp_ident_in;

   always_comb begin
      rsp_distance_in = (|a_dist_ff[DW-1:32]) ? 32'hFFFF_FFFF : a_dist_ff[31:0];
      rsp_ident_in    = report_id_ff ? signed'({1'b0, a_ident_ff}) : rbd_pkg::IDENT_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_o) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_o && a_valid_ff) begin
         rsp_distance_ff <= rsp_distance_in;
         rsp_detected_ff <= rsp_distance_in < max_range_ff;
         rsp_bearing_ff  <= a_bearing_ff;
         rsp_ident_ff    <= rsp_ident_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_detected       = rsp_detected_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_bearing        = signed'(rsp_bearing_ff);
   assign rsp_reported_ident = rsp_ident_ff;

   // Checks
   `ASSERT_ALWAYS(a_req_lands, clock, reset, req_valid && !req_stall |=> p_valid_ff)
   `ASSERT_ALWAYS(a_offset_holds, clock, reset, p_valid_ff && pipe_in_stall |=> p_valid_ff && $stable(p_item_ff))
   `ASSERT_ALWAYS(a_gain_holds, clock, reset, m_valid_ff && !adv_a |=> m_valid_ff && $stable(m_prod_hi_ff))
   `ASSERT_NEVER(a_sat_not_detected, clock, reset, rsp_valid_ff && rsp_detected_ff && (rsp_distance_ff == 32'hFFFF_FFFF))

endmodule

`default_nettype wire

// ===== dv/rbd_fix_checker.sv =====
`timescale 1ns / 100ps
// Checker for the beacon detector: mirrors the registers, predicts each fix and compares it.
module rbd_fix_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [31:0]                  req_sensor_x,
   input  logic signed [31:0]                  req_sensor_y,
   input  logic signed [15:0]                  req_sensor_heading,
   input  logic signed [31:0]                  req_beacon_x,
   input  logic signed [31:0]                  req_beacon_y,
   input  logic [15:0]                         req_beacon_ident,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_detected,
   input  logic [31:0]                         rsp_distance,
   input  logic signed [15:0]                  rsp_bearing,
   input  logic signed [16:0]                  rsp_reported_ident,
   input  logic                                csr_write,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_fixes
);

   typedef struct packed {
      logic        detected;
      logic [31:0] distance;
      logic [15:0] bearing;
      logic [16:0] ident;
   } beacon_fix_type;

   // atan(2^-i) as a 32-bit binary angle, truncated
   logic [31:0] arctan_step [0:31] = '{
      32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335086,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
      32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
      32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
   };

   logic [31:0]    range_limit;
   logic           ident_on;
   beacon_fix_type fix_q [$];
   beacon_fix_type want;
   beacon_fix_type next_fix;
   int             fix_seen;

   // Work out range, wrapped bearing, detect flag and identity for one beacon.
   function automatic beacon_fix_type locate_beacon(input logic signed [31:0] sx,
                                                    input logic signed [31:0] sy,
                                                    input logic [15:0]        heading,
                                                    input logic signed [31:0] bx,
                                                    input logic signed [31:0] by,
                                                    input logic [15:0]        ident,
                                                    input logic [31:0]        limit,
                                                    input logic               show_ident);
      beacon_fix_type f;
      longint         vx;
      longint         vy;
      longint         xs;
      longint         ys;
      logic [31:0]    turn;
      logic [31:0]    rounded;
      logic [95:0]    scaled;
      begin
         vx   = (longint'(bx) - longint'(sx)) <<< rbd_pkg::GUARD_BITS;
         vy   = (longint'(by) - longint'(sy)) <<< rbd_pkg::GUARD_BITS;
         turn = '0;
         // fold the left half-plane over and start the angle at pi
         if (vx < 0) begin
            vx   = -vx;
            vy   = -vy;
            turn = rbd_pkg::ANGLE_PI;
         end
         // rotate y toward zero, accumulating the angle
         for (int stage = 0; stage < rbd_pkg::CORDIC_STAGES && stage < 32; stage++) begin
            xs = vx >>> stage;
            ys = vy >>> stage;
            if (vy >= 0) begin
               vx   = vx + ys;
               vy   = vy - xs;
               turn = turn + arctan_step[stage];
            end else begin
               vx   = vx - ys;
               vy   = vy + xs;
               turn = turn - arctan_step[stage];
            end
         end
         if (vx < 0)
            vx = 0;
         // remove the gain and guard bits with rounding, then saturate
         scaled = 96'(vx) * 96'(rbd_pkg::INV_GAIN)
                + (96'd1 << (31 + rbd_pkg::GUARD_BITS));
         scaled = scaled >> (32 + rbd_pkg::GUARD_BITS);
         f.distance = (scaled > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
         rounded    = turn + rbd_pkg::ANGLE_ROUND;
         f.bearing  = rounded[31:16] - heading;
         f.detected = f.distance < limit;
         f.ident    = show_ident ? {1'b0, ident} : rbd_pkg::IDENT_NONE;
         return f;
      end
   endfunction

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      mismatch_count++;
      $display("[%0t] fix %0d %s: got 0x%h, want 0x%h",
               $time, fix_seen, what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         range_limit    = rbd_pkg::MAX_RANGE_RST;
         ident_on       = rbd_pkg::REPORT_ID_RST;
         mismatch_count = 0;
         fix_seen       = 0;
         fix_q.delete();
      end else begin
         // retire a result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (fix_q.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_distance, 32'h0);
            end else begin
               want = fix_q.pop_front();
               if (rsp_detected !== want.detected)
                  report_mismatch("detected", {31'h0, rsp_detected}, {31'h0, want.detected});
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_bearing !== want.bearing)
                  report_mismatch("bearing", {16'h0, rsp_bearing}, {16'h0, want.bearing});
               if (rsp_reported_ident !== want.ident)
                  report_mismatch("reported_ident", {15'h0, rsp_reported_ident},
                                  {15'h0, want.ident});
            end
            fix_seen++;
         end
         // predict each accepted request beat with the registers in force
         if (req_valid && !req_stall) begin
            next_fix = locate_beacon(req_sensor_x, req_sensor_y, req_sensor_heading,
                                     req_beacon_x, req_beacon_y, req_beacon_ident,
                                     range_limit, ident_on);
            fix_q    = {fix_q, next_fix};
         end
         // mirror register writes; unmapped indexes are dropped
         if (csr_write) begin
            case (csr_index)
               rbd_pkg::CSR_MAX_RANGE: range_limit = csr_wdata;
               rbd_pkg::CSR_REPORT_ID: ident_on = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending_fixes = fix_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the beacon detector: clock, reset, stimulus, back-pressure and verdict.
module tb_top;

   localparam int SETTLE_CYCLES = rbd_pkg::CORDIC_STAGES + 8;
   localparam int IDLE_LIMIT    = 1000;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 160;
   localparam int NEAR_SPAN     = 128 << 16;

   // Indexes past the register list; writes there must change nothing.
   localparam logic [rbd_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [rbd_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [31:0]                req_sensor_x = '0;
   logic signed [31:0]                req_sensor_y = '0;
   logic signed [15:0]                req_sensor_heading = '0;
   logic signed [31:0]                req_beacon_x = '0;
   logic signed [31:0]                req_beacon_y = '0;
   logic [15:0]                       req_beacon_ident = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_detected;
   logic [31:0]                       rsp_distance;
   logic signed [15:0]                rsp_bearing;
   logic signed [16:0]                rsp_reported_ident;
   logic                              csr_write = 1'b0;
   logic [rbd_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [31:0]                       csr_wdata = '0;

   int   mismatch_count;
   int   pending_fixes;
   logic req_fire = 1'b0;
   int   gap_pct = 0;
   int   stall_pct = 0;
   int   stall_left = 0;
   int   quiet_cycles = 0;

   range_bearing_beacon_detector u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sensor_x       (req_sensor_x),
      .req_sensor_y       (req_sensor_y),
      .req_sensor_heading (req_sensor_heading),
      .req_beacon_x       (req_beacon_x),
      .req_beacon_y       (req_beacon_y),
      .req_beacon_ident   (req_beacon_ident),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_detected       (rsp_detected),
      .rsp_distance       (rsp_distance),
      .rsp_bearing        (rsp_bearing),
      .rsp_reported_ident (rsp_reported_ident),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   rbd_fix_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sensor_x       (req_sensor_x),
      .req_sensor_y       (req_sensor_y),
      .req_sensor_heading (req_sensor_heading),
      .req_beacon_x       (req_beacon_x),
      .req_beacon_y       (req_beacon_y),
      .req_beacon_ident   (req_beacon_ident),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_detected       (rsp_detected),
      .rsp_distance       (rsp_distance),
      .rsp_bearing        (rsp_bearing),
      .rsp_reported_ident (rsp_reported_ident),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending_fixes      (pending_fixes)
   );

   always #6 clock = ~clock;

   // Record request acceptance at the edge for the driver to read at the falling edge.
   always @(posedge clock)
      req_fire <= req_valid && !req_stall;

   // Stall the result channel in random bursts of random length.
   always @(negedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Abort when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Present one request beat, with an optional gap first, and hold it until taken.
   task automatic send_beacon(input logic signed [31:0] sx, input logic signed [31:0] sy,
                              input logic [15:0] heading, input logic signed [31:0] bx,
                              input logic signed [31:0] by, input logic [15:0] ident);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_sensor_x       <= sx;
      req_sensor_y       <= sy;
      req_sensor_heading <= heading;
      req_beacon_x       <= bx;
      req_beacon_y       <= by;
      req_beacon_ident   <= ident;
      do @(negedge clock); while (!req_fire);
   endtask

   // Hold off requests until every predicted fix has come back, then let the pipe settle.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_fixes != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rbd_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Draw one beacon: mostly near the sensor, some far, some on axes, diagonals or at the sensor, some fully random.
   task automatic send_random_beacon();
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      int                 shape;
      shape = $urandom_range(0, 9);
      sx    = $urandom;
      sy    = $urandom;
      ox    = '0;
      oy    = '0;
      case (shape)
         0, 1: begin
            send_beacon(sx, sy, 16'($urandom), $urandom, $urandom, 16'($urandom));
         end
         2, 3, 4, 5, 6: begin
            ox = $urandom_range(0, 2 * NEAR_SPAN);
            oy = $urandom_range(0, 2 * NEAR_SPAN);
            ox = ox - NEAR_SPAN;
            oy = oy - NEAR_SPAN;
         end
         7, 8: begin
            ox = $urandom >> $urandom_range(1, 31);
            oy = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1)) ox = -ox;
            if ($urandom_range(0, 1)) oy = -oy;
         end
         default: begin
            ox = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1)) ox = -ox;
            case ($urandom_range(0, 3))
               0: oy = '0;
               1: begin oy = ox; ox = '0; end
               2: oy = $urandom_range(0, 1) ? ox : -ox;
               default: begin ox = '0; oy = '0; end
            endcase
         end
      endcase
      if (shape > 1) begin
         sx = sx >>> 1;
         sy = sy >>> 1;
         send_beacon(sx, sy, 16'($urandom), sx + ox, sy + oy, 16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats with the reset register values.
      send_beacon(0, 0, 16'h1234, 0, 0, 16'h0000);
      send_beacon(3 * Q_ONE, -Q_ONE, 16'h8000, 3 * Q_ONE, -Q_ONE, 16'hFFFF);
      send_beacon(0, 0, 16'h0000, Q_ONE, 0, 16'h0001);
      send_beacon(0, 0, 16'h0000, -Q_ONE, 0, 16'h0002);
      send_beacon(0, 0, 16'h0000, 0, Q_ONE, 16'h0003);
      send_beacon(0, 0, 16'h0000, 0, -Q_ONE, 16'h0004);
      send_beacon(0, 0, 16'h7FFF, -5 * Q_ONE, -7 * Q_ONE, 16'h0005);
      send_beacon(MOST_NEG, MOST_NEG, 16'h0000, MOST_POS, MOST_POS, 16'h0006);
      send_beacon(MOST_POS, MOST_POS, 16'h4000, MOST_NEG, MOST_NEG, 16'h0007);
      send_beacon(MOST_NEG, 0, 16'h0000, MOST_POS, 0, 16'h0008);
      send_beacon(1, 0, 16'h0000, 0, 0, 16'h0009);
      send_beacon(0, 1, 16'hC000, 0, 0, 16'h000A);
      send_beacon(0, 0, 16'h0000, rbd_pkg::MAX_RANGE_RST - 256, 0, 16'h000B);
      send_beacon(0, 0, 16'h0000, rbd_pkg::MAX_RANGE_RST, 0, 16'h000C);
      send_beacon(0, 0, 16'h0000, rbd_pkg::MAX_RANGE_RST + 256, 0, 16'h000D);
      send_beacon(-Q_ONE, -Q_ONE, 16'h0000, 2 * Q_ONE, 3 * Q_ONE, 16'h5A5A);

      // Identity off, and the limit at both extremes.
      drain_pipe();
      write_reg(rbd_pkg::CSR_REPORT_ID, 32'hFFFF_FFFE);
      write_reg(rbd_pkg::CSR_MAX_RANGE, 32'h0000_0000);
      send_beacon(0, 0, 16'h0000, 0, 0, 16'hA5A5);
      send_beacon(0, 0, 16'h0000, Q_ONE, Q_ONE, 16'hFFFF);
      drain_pipe();
      write_reg(rbd_pkg::CSR_MAX_RANGE, 32'hFFFF_FFFF);
      write_reg(rbd_pkg::CSR_REPORT_ID, 32'h0000_0001);
      send_beacon(0, 0, 16'h0000, 0, 0, 16'h0101);
      send_beacon(MOST_NEG, MOST_NEG, 16'h0000, MOST_POS, MOST_POS, 16'h0202);
      send_beacon(0, 0, 16'h0000, MOST_POS, MOST_POS, 16'h0303);

      // Writes past the register list must leave both registers alone.
      drain_pipe();
      write_reg(CSR_SPARE_LO, 32'h0000_0000);
      write_reg(CSR_SPARE_HI, 32'h0000_0000);
      send_beacon(0, 0, 16'h0000, 100 * Q_ONE, 0, 16'h0404);

      // Random phases, each under its own register setting and idling mix.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_pipe();
         case (phase % 4)
            0: write_reg(rbd_pkg::CSR_MAX_RANGE, 32'h0000_0000);
            1: write_reg(rbd_pkg::CSR_MAX_RANGE, 32'hFFFF_FFFF);
            2: write_reg(rbd_pkg::CSR_MAX_RANGE, rbd_pkg::MAX_RANGE_RST);
            default: write_reg(rbd_pkg::CSR_MAX_RANGE, $urandom_range(0, 200 << 16));
         endcase
         write_reg(rbd_pkg::CSR_REPORT_ID, $urandom);
         if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
         if (phase == PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = 10 * $urandom_range(0, 3);
            stall_pct = 10 * $urandom_range(0, 3);
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            send_random_beacon();
            if ($urandom_range(0, 299) == 0)
               drain_pipe();
         end
      end

      drain_pipe();
      if (mismatch_count == 0 && pending_fixes == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
